@@ design/tchfe_pkg.sv @@
// shared types, constants and helpers for the client hello field extractor
// no dependencies

package tchfe_pkg;

    localparam int MAX_CIPHERS    = 64;
    localparam int MAX_EXTENSIONS = 64;
    localparam int MAX_SIG_ALGS   = 64;

    // list counters hold up to 511
    localparam int CNT_W = 9;

    localparam logic [1:0] KIND_CIPHER  = 2'd0;
    localparam logic [1:0] KIND_EXT     = 2'd1;
    localparam logic [1:0] KIND_SIG_ALG = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [15:0] EXT_SNI      = 16'd0;
    localparam logic [15:0] EXT_SIG_ALGS = 16'd13;
    localparam logic [15:0] EXT_ALPN     = 16'd16;
    localparam logic [15:0] EXT_VERSIONS = 16'd43;

    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic        status;
        logic [15:0] hello_ver;
        logic        sni_host_present;
        logic        sig_algs_present;
        logic [7:0]  alpn_head;
        logic [7:0]  alpn_tail;
        logic [15:0] versions_max;
        logic [6:0]  cipher_count;
        logic [6:0]  extension_count;
        logic [6:0]  sig_alg_count;
    } t_result;

    // grease: low nibbles are 0xA in both bytes and high nibbles match
    function automatic logic is_grease(input logic [15:0] v);
        return ((v & 16'h0F0F) == 16'h0A0A) && (v[7:4] == v[15:12]);
    endfunction

endpackage

@@ design/tchfe_if.sv @@
// valid/ready channel interfaces for input bytes and result words
// depends on tchfe_pkg

interface tchfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tchfe_out_if import tchfe_pkg::*;;
    logic    valid;
    logic    ready;
    t_result res;
    modport source (output valid, output res, input ready);
    modport sink (input valid, input res, output ready);
endinterface

@@ design/tchfe_parser.sv @@
// byte-serial client hello walker: one byte per cycle while i_take is high, up to two result words
// depends on tchfe_pkg

module tchfe_parser import tchfe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output logic        o_item_valid,
    output t_result     o_item,
    output logic        o_sum_valid,
    output t_result     o_sum
);

    typedef enum logic [4:0] {
        P_TYPE, P_LEN1, P_LEN2, P_LEN3, P_VER_HI, P_VER_LO, P_RANDOM,
        P_SID_LEN, P_SID, P_CS_HI, P_CS_LO, P_CI_HI, P_CI_LO, P_COMP_LEN,
        P_COMP, P_EXT_TOT_HI, P_EXT_TOT_LO, P_EXT_T_HI, P_EXT_T_LO,
        P_EXT_L_HI, P_EXT_L_LO, P_EXT_BODY, P_DONE
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [23:0]      r_body, n_body;
    logic [15:0]      r_field, n_field;
    logic [15:0]      r_ebr, n_ebr;
    logic [15:0]      r_etype, n_etype;
    logic [15:0]      r_elen, n_elen;
    logic [15:0]      r_eoff, n_eoff;
    logic [15:0]      r_ill, n_ill;
    logic [7:0]       r_hold, n_hold;
    logic [7:0]       r_plen, n_plen;
    logic [15:0]      r_rvmax, n_rvmax;
    logic             r_iok, n_iok;
    logic [15:0]      r_legacy, n_legacy;
    logic             r_sni, n_sni;
    logic             r_sig, n_sig;
    logic [7:0]       r_afirst, n_afirst;
    logic [7:0]       r_alast, n_alast;
    logic [15:0]      r_vmax, n_vmax;
    logic [CNT_W-1:0] r_ccnt, n_ccnt;
    logic [CNT_W-1:0] r_ecnt, n_ecnt;
    logic [CNT_W-1:0] r_scnt, n_scnt;
    logic             r_err, n_err;

    logic [15:0] w_word;
    logic [23:0] w_br;
    logic [16:0] w_ill2;
    logic        w_go;

    assign w_word = {r_hold, i_byte};

    // next state and emitted words for the byte on the input
    always_comb begin
        n_phase = r_phase;   n_body = r_body;     n_field = r_field;
        n_ebr = r_ebr;       n_etype = r_etype;   n_elen = r_elen;
        n_eoff = r_eoff;     n_ill = r_ill;       n_hold = r_hold;
        n_plen = r_plen;     n_rvmax = r_rvmax;   n_iok = r_iok;
        n_legacy = r_legacy; n_sni = r_sni;       n_sig = r_sig;
        n_afirst = r_afirst; n_alast = r_alast;   n_vmax = r_vmax;
        n_ccnt = r_ccnt;     n_ecnt = r_ecnt;     n_scnt = r_scnt;
        n_err = r_err;
        o_item_valid = 1'b0;
        o_item = '0;
        o_sum_valid = 1'b0;
        o_sum = '0;
        w_br = r_body - 24'd1;
        w_ill2 = {1'b0, r_ill} + 17'd2;
        w_go = 1'b0;

        if (!r_err && r_phase != P_DONE) begin
            // header bytes before the body
            if (r_phase == P_TYPE) begin
                if (i_byte != 8'd1) n_err = 1'b1;
                else n_phase = P_LEN1;
            end else if (r_phase == P_LEN1) begin
                n_body = {i_byte, 16'd0};
                n_phase = P_LEN2;
            end else if (r_phase == P_LEN2) begin
                n_body = {r_body[23:16], i_byte, 8'd0};
                n_phase = P_LEN3;
            end else if (r_phase == P_LEN3) begin
                n_body = {r_body[23:8], i_byte};
                if ({r_body[23:8], i_byte} < 24'd34) n_err = 1'b1;
                else n_phase = P_VER_HI;
            end else if (r_body == 24'd0) begin
                n_err = 1'b1;
            end else begin
                n_body = w_br;
                w_go = 1'b1;
                if (r_phase >= P_EXT_T_HI) begin
                    if (r_ebr == 16'd0) begin
                        n_err = 1'b1;
                        w_go = 1'b0;
                    end else begin
                        n_ebr = r_ebr - 16'd1;
                    end
                end
            end

            // body bytes
            if (w_go) begin
                unique case (r_phase)
                    P_VER_HI: begin
                        n_hold = i_byte;
                        n_phase = P_VER_LO;
                    end
                    P_VER_LO: begin
                        n_legacy = w_word;
                        n_field = 16'd32;
                        n_phase = P_RANDOM;
                    end
                    P_RANDOM: begin
                        n_field = r_field - 16'd1;
                        if (r_field == 16'd1) begin
                            if (w_br == 24'd0) n_err = 1'b1;
                            else n_phase = P_SID_LEN;
                        end
                    end
                    P_SID_LEN: begin
                        if (w_br < {16'd0, i_byte}) begin
                            n_err = 1'b1;
                        end else begin
                            n_field = {8'd0, i_byte};
                            if (i_byte != 8'd0) n_phase = P_SID;
                            else if (w_br < 24'd2) n_err = 1'b1;
                            else n_phase = P_CS_HI;
                        end
                    end
                    P_SID: begin
                        n_field = r_field - 16'd1;
                        if (r_field == 16'd1) begin
                            if (w_br < 24'd2) n_err = 1'b1;
                            else n_phase = P_CS_HI;
                        end
                    end
                    P_CS_HI: begin
                        n_hold = i_byte;
                        n_phase = P_CS_LO;
                    end
                    P_CS_LO: begin
                        if (w_br < {8'd0, w_word} || w_word[0]) begin
                            n_err = 1'b1;
                        end else begin
                            n_field = w_word;
                            if (w_word != 16'd0) n_phase = P_CI_HI;
                            else if (w_br == 24'd0) n_err = 1'b1;
                            else n_phase = P_COMP_LEN;
                        end
                    end
                    P_CI_HI: begin
                        n_hold = i_byte;
                        n_field = r_field - 16'd1;
                        n_phase = P_CI_LO;
                    end
                    P_CI_LO: begin
                        n_field = r_field - 16'd1;
                        if (r_field != 16'd1) n_phase = P_CI_HI;
                        else if (w_br == 24'd0) n_err = 1'b1;
                        else n_phase = P_COMP_LEN;
                        if (!is_grease(w_word) && r_ccnt < CNT_W'(MAX_CIPHERS)) begin
                            n_ccnt = r_ccnt + 1'b1;
                            o_item_valid = 1'b1;
                            o_item.kind = KIND_CIPHER;
                            o_item.value = w_word;
                        end
                    end
                    P_COMP_LEN: begin
                        if (w_br < {16'd0, i_byte}) begin
                            n_err = 1'b1;
                        end else begin
                            n_field = {8'd0, i_byte};
                            if (i_byte != 8'd0) n_phase = P_COMP;
                            else if (w_br == 24'd0) n_phase = P_DONE;
                            else if (w_br < 24'd2) n_err = 1'b1;
                            else n_phase = P_EXT_TOT_HI;
                        end
                    end
                    P_COMP: begin
                        n_field = r_field - 16'd1;
                        if (r_field == 16'd1) begin
                            if (w_br == 24'd0) n_phase = P_DONE;
                            else if (w_br < 24'd2) n_err = 1'b1;
                            else n_phase = P_EXT_TOT_HI;
                        end
                    end
                    P_EXT_TOT_HI: begin
                        n_hold = i_byte;
                        n_phase = P_EXT_TOT_LO;
                    end
                    P_EXT_TOT_LO: begin
                        if (w_br < {8'd0, w_word}) begin
                            n_err = 1'b1;
                        end else begin
                            n_ebr = w_word;
                            n_phase = (w_word < 16'd4) ? P_DONE : P_EXT_T_HI;
                        end
                    end
                    P_EXT_T_HI: begin
                        n_hold = i_byte;
                        n_phase = P_EXT_T_LO;
                    end
                    P_EXT_T_LO: begin
                        n_etype = w_word;
                        n_phase = P_EXT_L_HI;
                    end
                    P_EXT_L_HI: begin
                        n_hold = i_byte;
                        n_phase = P_EXT_L_LO;
                    end
                    P_EXT_L_LO: begin
                        n_elen = w_word;
                        if (n_ebr < w_word) begin
                            n_err = 1'b1;
                        end else begin
                            if (r_etype == EXT_SIG_ALGS) n_sig = 1'b1;
                            n_eoff = 16'd0;
                            n_iok = 1'b0;
                            if (w_word != 16'd0) n_phase = P_EXT_BODY;
                            else n_phase = (n_ebr < 16'd4) ? P_DONE : P_EXT_T_HI;
                            if (!is_grease(r_etype) && r_ecnt < CNT_W'(MAX_EXTENSIONS)) begin
                                n_ecnt = r_ecnt + 1'b1;
                                o_item_valid = 1'b1;
                                o_item.kind = KIND_EXT;
                                o_item.value = r_etype;
                            end
                        end
                    end
                    P_EXT_BODY: begin
                        // extension payload decode by type
                        if (r_etype == EXT_SNI) begin
                            if (r_eoff == 16'd0) n_hold = i_byte;
                            else if (r_eoff == 16'd1) n_ill = w_word;
                            else if (r_eoff == 16'd2 && r_elen >= 16'd5
                                     && w_ill2 <= {1'b0, r_elen} && r_ill >= 16'd3
                                     && i_byte == 8'd0) n_sni = 1'b1;
                        end else if (r_etype == EXT_SIG_ALGS) begin
                            if (r_eoff == 16'd0) begin
                                n_hold = i_byte;
                            end else if (r_eoff == 16'd1) begin
                                n_ill = w_word;
                                n_iok = ({1'b0, w_word} + 17'd2 <= {1'b0, r_elen})
                                        && !w_word[0];
                            end else if (r_iok && {1'b0, r_eoff} < w_ill2) begin
                                if (!r_eoff[0]) begin
                                    n_hold = i_byte;
                                end else if (!is_grease(w_word)
                                             && r_scnt < CNT_W'(MAX_SIG_ALGS)) begin
                                    n_scnt = r_scnt + 1'b1;
                                    o_item_valid = 1'b1;
                                    o_item.kind = KIND_SIG_ALG;
                                    o_item.value = w_word;
                                end
                            end
                        end else if (r_etype == EXT_ALPN) begin
                            if (r_eoff == 16'd0) begin
                                n_hold = i_byte;
                            end else if (r_eoff == 16'd1) begin
                                n_ill = w_word;
                                n_iok = r_elen >= 16'd3 && w_word != 16'd0
                                        && ({1'b0, w_word} + 17'd2 <= {1'b0, r_elen});
                            end else if (r_eoff == 16'd2) begin
                                if (r_iok) begin
                                    n_plen = i_byte;
                                    n_iok = i_byte != 8'd0
                                            && ({9'd0, i_byte} + 17'd3 <= {1'b0, r_elen});
                                end
                            end else if (r_iok) begin
                                if (r_eoff == 16'd3) n_afirst = i_byte;
                                if ({1'b0, r_eoff} == {9'd0, r_plen} + 17'd2)
                                    n_alast = i_byte;
                            end
                        end else if (r_etype == EXT_VERSIONS) begin
                            if (r_eoff == 16'd0) begin
                                n_ill = {8'd0, i_byte};
                                n_iok = ({9'd0, i_byte} + 17'd1 <= {1'b0, r_elen})
                                        && !i_byte[0];
                                if (n_iok) begin
                                    n_rvmax = 16'd0;
                                    if (i_byte == 8'd0) n_vmax = 16'd0;
                                end
                            end else if (r_iok && r_eoff <= r_ill) begin
                                if (r_eoff[0]) begin
                                    n_hold = i_byte;
                                end else begin
                                    if (!is_grease(w_word) && w_word > r_rvmax)
                                        n_rvmax = w_word;
                                    if (r_eoff == r_ill) n_vmax = n_rvmax;
                                end
                            end
                        end
                        n_eoff = r_eoff + 16'd1;
                        if (n_eoff == r_elen)
                            n_phase = (n_ebr < 16'd4) ? P_DONE : P_EXT_T_HI;
                    end
                    default: n_err = 1'b1;
                endcase
            end
        end else if (r_phase == P_DONE && r_body != 24'd0) begin
            n_body = r_body - 24'd1;
        end

        // summary word, then back to the start of a message
        if (i_last) begin
            o_sum_valid = 1'b1;
            o_sum.kind = KIND_SUMMARY;
            o_sum.status = !(!n_err && n_phase == P_DONE && n_body == 24'd0);
            o_sum.hello_ver = n_legacy;
            o_sum.sni_host_present = n_sni;
            o_sum.sig_algs_present = n_sig;
            o_sum.alpn_head = n_afirst;
            o_sum.alpn_tail = n_alast;
            o_sum.versions_max = n_vmax;
            o_sum.cipher_count = n_ccnt[6:0];
            o_sum.extension_count = n_ecnt[6:0];
            o_sum.sig_alg_count = n_scnt[6:0];
            n_phase = P_TYPE;   n_body = '0;   n_field = '0;  n_ebr = '0;
            n_etype = '0;       n_elen = '0;   n_eoff = '0;   n_ill = '0;
            n_hold = '0;        n_plen = '0;   n_rvmax = '0;  n_iok = 1'b0;
            n_legacy = '0;      n_sni = 1'b0;  n_sig = 1'b0;
            n_afirst = ASCII_ZERO; n_alast = ASCII_ZERO;   n_vmax = '0;
            n_ccnt = '0;        n_ecnt = '0;   n_scnt = '0;   n_err = 1'b0;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_TYPE;  r_body <= '0;   r_field <= '0;  r_ebr <= '0;
            r_etype <= '0;      r_elen <= '0;   r_eoff <= '0;   r_ill <= '0;
            r_hold <= '0;       r_plen <= '0;   r_rvmax <= '0;  r_iok <= 1'b0;
            r_legacy <= '0;     r_sni <= 1'b0;  r_sig <= 1'b0;
            r_afirst <= ASCII_ZERO; r_alast <= ASCII_ZERO;  r_vmax <= '0;
            r_ccnt <= '0;       r_ecnt <= '0;   r_scnt <= '0;   r_err <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;  r_body <= n_body;   r_field <= n_field;
            r_ebr <= n_ebr;      r_etype <= n_etype; r_elen <= n_elen;
            r_eoff <= n_eoff;    r_ill <= n_ill;     r_hold <= n_hold;
            r_plen <= n_plen;    r_rvmax <= n_rvmax; r_iok <= n_iok;
            r_legacy <= n_legacy; r_sni <= n_sni;    r_sig <= n_sig;
            r_afirst <= n_afirst; r_alast <= n_alast; r_vmax <= n_vmax;
            r_ccnt <= n_ccnt;    r_ecnt <= n_ecnt;   r_scnt <= n_scnt;
            r_err <= n_err;
        end
    end

endmodule

@@ design/tchfe_out_fifo.sv @@
// four-entry result queue: takes up to two words per cycle, gives one
// depends on tchfe_pkg

module tchfe_out_fifo import tchfe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push0,
    input  t_result i_word0,
    input  logic    i_push1,
    input  t_result i_word1,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_word,
    input  logic    i_pop
);

    t_result    r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic [1:0] w_wr1;
    logic       w_pop;

    assign o_valid = r_cnt != 3'd0;
    assign o_word  = r_mem[r_rd];
    assign o_room  = r_cnt <= 3'd2;
    assign w_pop   = i_pop && o_valid;
    assign w_wr1   = i_push0 ? r_wr + 2'd1 : r_wr;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push0) r_mem[r_wr] <= i_word0;
        if (i_push1) r_mem[w_wr1] <= i_word1;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= r_wr + {1'b0, i_push0} + {1'b0, i_push1};
            if (w_pop) r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'b0, i_push0} + {2'b0, i_push1} - {2'b0, w_pop};
        end
    end

endmodule

@@ design/tls_client_hello_field_extractor.sv @@
// top level of the client hello field extractor: parser plus result queue
// depends on tchfe_pkg, tchfe_if, tchfe_parser, tchfe_out_fifo
//
//   channel  dir  payload                         handshake
//   i_in     in   data_byte, last_byte            valid/ready
//   o_out    out  t_result (kind, value, summary) valid/ready
//
// one byte is taken per cycle while the queue has room; each byte yields zero, one or two words
// (a list entry and, on the last byte, the summary), queued four deep
// a word leaves the queue in the cycle after its byte at the earliest
// the input stalls only while the queue holds three or more words
// reset is synchronous, active low, and returns to the message start

module tls_client_hello_field_extractor import tchfe_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tchfe_in_if.sink       i_in,
    tchfe_out_if.source    o_out
);

    logic    w_room, w_take;
    logic    w_item_valid, w_sum_valid;
    t_result w_item, w_sum;

    assign i_in.ready = w_room;
    assign w_take = i_in.valid && w_room;

    tchfe_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_byte       (i_in.data_byte),
        .i_last       (i_in.last_byte),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .o_sum_valid  (w_sum_valid),
        .o_sum        (w_sum)
    );

    tchfe_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_take && w_item_valid),
        .i_word0 (w_item),
        .i_push1 (w_take && w_sum_valid),
        .i_word1 (w_sum),
        .o_room  (w_room),
        .o_valid (o_out.valid),
        .o_word  (o_out.res),
        .i_pop   (o_out.ready)
    );

endmodule

@@ test/tchfe_checker.sv @@
// checker for the client hello field extractor: watches both channels,
// predicts the result words of every accepted byte and compares them in order
// depends on tchfe_pkg and tchfe_if

module tchfe_checker import tchfe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tchfe_in_if   mon_in,
    tchfe_out_if  mon_out,
    output int    o_fail_count,
    output int    o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        PH_TYPE, PH_LEN1, PH_LEN2, PH_LEN3, PH_VER_HI, PH_VER_LO, PH_RANDOM,
        PH_SID_LEN, PH_SID, PH_CS_HI, PH_CS_LO, PH_CI_HI, PH_CI_LO, PH_COMP_LEN,
        PH_COMP, PH_EXT_TOT_HI, PH_EXT_TOT_LO, PH_EXT_T_HI, PH_EXT_T_LO,
        PH_EXT_L_HI, PH_EXT_L_LO, PH_EXT_BODY, PH_DONE
    } t_phase;

    // parser state mirror
    t_phase      phase;
    logic [23:0] body_left;
    logic [15:0] field_left, block_left, ext_code, ext_len, ext_pos, inner_len;
    logic [7:0]  hold, name_bytes;
    logic [15:0] run_max;
    bit          list_ok, err;
    logic [15:0] legacy, vers_max;
    logic        sni_host, sig_seen;
    logic [7:0]  alpn_a, alpn_z;
    int          n_ciph, n_ext, n_sig;

    t_result expected_words[$];

    function automatic bit grease_code(input logic [15:0] v);
        return (v[11:8] == 4'hA) && (v[3:0] == 4'hA) && (v[15:12] == v[7:4]);
    endfunction

    function automatic void clear_state();
        phase = PH_TYPE;
        body_left = '0; field_left = '0; block_left = '0; ext_code = '0;
        ext_len = '0; ext_pos = '0; inner_len = '0; hold = '0; name_bytes = '0;
        run_max = '0; list_ok = 0; err = 0;
        legacy = '0; sni_host = 0; sig_seen = 0; alpn_a = ASCII_ZERO;
        alpn_z = ASCII_ZERO; vers_max = '0; n_ciph = 0; n_ext = 0; n_sig = 0;
    endfunction

    function automatic void push_entry(input logic [1:0] k, input logic [15:0] v);
        t_result r;
        r = '0;
        r.kind = k;
        r.value = v;
        expected_words.push_back(r);
    endfunction

    function automatic void ext_hdr_next();
        phase = (block_left < 4) ? PH_DONE : PH_EXT_T_HI;
    endfunction

    function automatic void to_cs_len(input logic [23:0] br);
        if (br < 2) err = 1; else phase = PH_CS_HI;
    endfunction

    function automatic void to_comp_len(input logic [23:0] br);
        if (br < 1) err = 1; else phase = PH_COMP_LEN;
    endfunction

    function automatic void after_comp(input logic [23:0] br);
        if (br == 0) phase = PH_DONE;
        else if (br < 2) err = 1;
        else phase = PH_EXT_TOT_HI;
    endfunction

    // one byte inside an extension body
    function automatic void ext_byte(input logic [7:0] b);
        logic [15:0] o, v;
        o = ext_pos;
        if (ext_code == EXT_SNI) begin
            if (o == 0) hold = b;
            else if (o == 1) inner_len = {hold, b};
            else if (o == 2 && ext_len >= 5 && inner_len + 2 <= ext_len
                     && inner_len >= 3 && b == 0) sni_host = 1;
        end else if (ext_code == EXT_SIG_ALGS) begin
            if (o == 0) hold = b;
            else if (o == 1) begin
                inner_len = {hold, b};
                list_ok = (inner_len + 2 <= ext_len) && !inner_len[0];
            end else if (list_ok && o < 2 + inner_len) begin
                if (!o[0]) hold = b;
                else begin
                    v = {hold, b};
                    if (!grease_code(v) && n_sig < MAX_SIG_ALGS) begin
                        n_sig++;
                        push_entry(KIND_SIG_ALG, v);
                    end
                end
            end
        end else if (ext_code == EXT_ALPN) begin
            if (o == 0) hold = b;
            else if (o == 1) begin
                inner_len = {hold, b};
                list_ok = ext_len >= 3 && inner_len + 2 <= ext_len && inner_len >= 1;
            end else if (o == 2) begin
                if (list_ok) begin
                    name_bytes = b;
                    list_ok = b >= 1 && b + 3 <= ext_len;
                end
            end else if (list_ok) begin
                if (o == 3) alpn_a = b;
                if (o == 2 + name_bytes) alpn_z = b;
            end
        end else if (ext_code == EXT_VERSIONS) begin
            if (o == 0) begin
                inner_len = {8'd0, b};
                list_ok = (b + 1 <= ext_len) && !b[0];
                if (list_ok) begin
                    run_max = '0;
                    if (b == 0) vers_max = '0;
                end
            end else if (list_ok && o <= inner_len) begin
                if (o[0]) hold = b;
                else begin
                    v = {hold, b};
                    if (!grease_code(v) && v > run_max) run_max = v;
                    if (o == inner_len) vers_max = run_max;
                end
            end
        end
        ext_pos = ext_pos + 16'd1;
        if (ext_pos == ext_len) ext_hdr_next();
    endfunction

    // one byte of the message while parsing is live
    function automatic void parse_byte(input logic [7:0] b);
        logic [23:0] br;
        logic [15:0] v;
        case (phase)
            PH_TYPE: begin
                if (b != 8'd1) err = 1; else phase = PH_LEN1;
                return;
            end
            PH_LEN1: begin body_left = {b, 16'h0}; phase = PH_LEN2; return; end
            PH_LEN2: begin body_left[15:8] = b; phase = PH_LEN3; return; end
            PH_LEN3: begin
                body_left[7:0] = b;
                if (body_left < 34) err = 1; else phase = PH_VER_HI;
                return;
            end
            default: ;
        endcase
        if (body_left == 0) begin err = 1; return; end
        body_left = body_left - 24'd1;
        br = body_left;
        if (phase >= PH_EXT_T_HI) begin
            if (block_left == 0) begin err = 1; return; end
            block_left = block_left - 16'd1;
        end
        case (phase)
            PH_VER_HI: begin hold = b; phase = PH_VER_LO; end
            PH_VER_LO: begin legacy = {hold, b}; field_left = 16'd32; phase = PH_RANDOM; end
            PH_RANDOM: begin
                field_left = field_left - 16'd1;
                if (field_left == 0) begin
                    if (br < 1) err = 1; else phase = PH_SID_LEN;
                end
            end
            PH_SID_LEN: begin
                if (br < b) err = 1;
                else begin
                    field_left = {8'd0, b};
                    if (b == 0) to_cs_len(br); else phase = PH_SID;
                end
            end
            PH_SID: begin
                field_left = field_left - 16'd1;
                if (field_left == 0) to_cs_len(br);
            end
            PH_CS_HI: begin hold = b; phase = PH_CS_LO; end
            PH_CS_LO: begin
                v = {hold, b};
                if (br < v || v[0]) err = 1;
                else begin
                    field_left = v;
                    if (v == 0) to_comp_len(br); else phase = PH_CI_HI;
                end
            end
            PH_CI_HI: begin hold = b; field_left = field_left - 16'd1; phase = PH_CI_LO; end
            PH_CI_LO: begin
                field_left = field_left - 16'd1;
                v = {hold, b};
                if (field_left == 0) to_comp_len(br); else phase = PH_CI_HI;
                if (!grease_code(v) && n_ciph < MAX_CIPHERS) begin
                    n_ciph++;
                    push_entry(KIND_CIPHER, v);
                end
            end
            PH_COMP_LEN: begin
                if (br < b) err = 1;
                else begin
                    field_left = {8'd0, b};
                    if (b == 0) after_comp(br); else phase = PH_COMP;
                end
            end
            PH_COMP: begin
                field_left = field_left - 16'd1;
                if (field_left == 0) after_comp(br);
            end
            PH_EXT_TOT_HI: begin hold = b; phase = PH_EXT_TOT_LO; end
            PH_EXT_TOT_LO: begin
                v = {hold, b};
                if (br < v) err = 1;
                else begin
                    block_left = v;
                    ext_hdr_next();
                end
            end
            PH_EXT_T_HI: begin hold = b; phase = PH_EXT_T_LO; end
            PH_EXT_T_LO: begin ext_code = {hold, b}; phase = PH_EXT_L_HI; end
            PH_EXT_L_HI: begin hold = b; phase = PH_EXT_L_LO; end
            PH_EXT_L_LO: begin
                ext_len = {hold, b};
                if (block_left < ext_len) err = 1;
                else begin
                    if (ext_code == EXT_SIG_ALGS) sig_seen = 1;
                    ext_pos = '0;
                    list_ok = 0;
                    if (ext_len == 0) ext_hdr_next(); else phase = PH_EXT_BODY;
                    if (!grease_code(ext_code) && n_ext < MAX_EXTENSIONS) begin
                        n_ext++;
                        push_entry(KIND_EXT, ext_code);
                    end
                end
            end
            PH_EXT_BODY: ext_byte(b);
            default: err = 1;
        endcase
    endfunction

    // expected words for one accepted byte
    function automatic void predict_word(input logic [7:0] b, input logic last);
        t_result s;
        if (!err && phase != PH_DONE) parse_byte(b);
        else if (phase == PH_DONE && body_left > 0) body_left = body_left - 24'd1;
        if (last) begin
            s = '0;
            s.kind = KIND_SUMMARY;
            s.status = !(!err && phase == PH_DONE && body_left == 0);
            s.hello_ver = legacy;
            s.sni_host_present = sni_host;
            s.sig_algs_present = sig_seen;
            s.alpn_head = alpn_a;
            s.alpn_tail = alpn_z;
            s.versions_max = vers_max;
            s.cipher_count = n_ciph[6:0];
            s.extension_count = n_ext[6:0];
            s.sig_alg_count = n_sig[6:0];
            expected_words.push_back(s);
            clear_state();
        end
    endfunction

    // predict on accepted bytes, compare on accepted words
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (mon_in.valid && mon_in.ready)
                predict_word(mon_in.data_byte, mon_in.last_byte);
            if (mon_out.valid && mon_out.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h", $time,
                             mon_out.res);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want !== mon_out.res) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want,
                                 mon_out.res);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_words_pending <= expected_words.size();
    end

    initial begin
        clear_state();
    end
endmodule

@@ test/tb_tls_client_hello_field_extractor.sv @@
// testbench top for the client hello field extractor: builds hello messages,
// drives them byte by byte with random gaps and stalls, gives the verdict
// depends on tchfe_pkg, tchfe_if, the block and tchfe_checker

module tb_tls_client_hello_field_extractor import tchfe_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   fail_count, words_pending;
    int   cycles = 0;
    int   bytes_sent = 0;
    int   idle_pct = 0, stall_pct = 0;

    tchfe_in_if  in_ch ();
    tchfe_out_if out_ch ();

    tls_client_hello_field_extractor dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    tchfe_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .mon_in         (in_ch),
        .mon_out        (out_ch),
        .o_fail_count   (fail_count),
        .o_words_pending(words_pending)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    logic [7:0] msg[$], body[$], xblk[$], cont[$];

    function automatic logic [15:0] pick_code(input logic [15:0] usual);
        logic [3:0] n;
        n = 4'($urandom_range(15));
        case ($urandom_range(3))
            0: return {n, 4'hA, n, 4'hA};
            1: return usual;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic void add_ext(input logic [15:0] code);
        xblk.push_back(code[15:8]);
        xblk.push_back(code[7:0]);
        xblk.push_back(8'(cont.size() >> 8));
        xblk.push_back(8'(cont.size()));
        foreach (cont[i]) xblk.push_back(cont[i]);
        cont.delete();
    endfunction

    // well formed hello with random content
    function automatic void build_hello(input int n_suites);
        int n, k;
        logic [15:0] v;
        body.delete(); xblk.delete(); cont.delete(); msg.delete();
        v = ($urandom_range(3) == 0) ? 16'($urandom) : 16'h0303;
        body.push_back(v[15:8]); body.push_back(v[7:0]);
        repeat (32) body.push_back(8'($urandom));
        n = ($urandom_range(2) == 0) ? $urandom_range(32) : 0;
        body.push_back(8'(n));
        repeat (n) body.push_back(8'($urandom));
        body.push_back(8'((2 * n_suites) >> 8)); body.push_back(8'(2 * n_suites));
        repeat (n_suites) begin
            v = pick_code(16'h1301);
            body.push_back(v[15:8]); body.push_back(v[7:0]);
        end
        n = $urandom_range(1, 2);
        body.push_back(8'(n));
        repeat (n) body.push_back(8'($urandom));
        if ($urandom_range(7) != 0) begin
            repeat ($urandom_range(4)) begin
                case ($urandom_range(5))
                    0: begin
                        n = $urandom_range(1, 4);
                        cont = '{8'd0, 8'(n + 3),
                                 ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00,
                                 8'd0, 8'(n)};
                        repeat (n) cont.push_back(8'($urandom));
                        add_ext(EXT_SNI);
                    end
                    1: begin
                        n = $urandom_range(1, 5);
                        cont = '{8'd0, 8'(n + 1), 8'(n)};
                        repeat (n) cont.push_back(8'($urandom));
                        add_ext(EXT_ALPN);
                    end
                    2: begin
                        k = $urandom_range(4);
                        cont = '{8'd0, 8'(2 * k)};
                        repeat (k) begin
                            v = pick_code(16'h0403);
                            cont.push_back(v[15:8]); cont.push_back(v[7:0]);
                        end
                        add_ext(EXT_SIG_ALGS);
                    end
                    3: begin
                        k = $urandom_range(3);
                        cont = '{8'(2 * k)};
                        repeat (k) begin
                            v = pick_code(16'h0304);
                            cont.push_back(v[15:8]); cont.push_back(v[7:0]);
                        end
                        add_ext(EXT_VERSIONS);
                    end
                    default: begin
                        repeat ($urandom_range(3)) cont.push_back(8'($urandom));
                        add_ext(pick_code(16'h0017));
                    end
                endcase
            end
            // short slack at the end of the extension block
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 3)) xblk.push_back(8'($urandom));
            body.push_back(8'(xblk.size() >> 8)); body.push_back(8'(xblk.size()));
            foreach (xblk[i]) body.push_back(xblk[i]);
            // body bytes beyond the extension block
            if ($urandom_range(6) == 0)
                repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
        end
        msg = '{8'h01, 8'(body.size() >> 16), 8'(body.size() >> 8), 8'(body.size())};
        foreach (body[i]) msg.push_back(body[i]);
    endfunction

    // idling mix follows the number of bytes sent
    function automatic void set_idling();
        case ((bytes_sent / 150) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            default: begin idle_pct = 20; stall_pct = 20; end
        endcase
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        set_idling();
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= last;
        forever begin
            @(negedge i_clk);
            if (in_ch.ready) break;
        end
        @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_msg();
        foreach (msg[i]) send_word(msg[i], i == msg.size() - 1);
    endtask

    initial begin
        int cut;
        in_ch.valid = 0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: wrong type, short body, truncated body, no cipher suites, list cap
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        msg = '{8'h01, 8'h00, 8'h00, 8'h21, 8'h03};
        send_msg();
        msg = '{8'h01, 8'hFF, 8'hFF, 8'hFF};
        send_msg();
        build_hello(0);
        send_msg();
        build_hello(70);
        send_msg();

        // random: mostly valid hellos, some damaged, some noise
        while (bytes_sent < 500) begin
            case ($urandom_range(9))
                0: begin
                    msg.delete();
                    repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
                end
                1, 2: begin
                    build_hello($urandom_range(6));
                    msg[$urandom_range(msg.size() - 1)] = 8'($urandom);
                end
                3: begin
                    build_hello($urandom_range(6));
                    cut = $urandom_range(1, msg.size() - 1);
                    while (msg.size() > cut) void'(msg.pop_back());
                end
                4: begin
                    build_hello($urandom_range(6));
                    repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
                end
                default: build_hello($urandom_range(6));
            endcase
            send_msg();
        end
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
